>>> rtl/hsvc_pkg.sv
`timescale 1ns / 1ps
// hsvc_pkg: shared constants, stage payload types and helpers of the hsv to rgb converter
// depends on nothing; used by every module under rtl

package hsvc_pkg;

   // fixed-point format of the fractions
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 17;
   localparam int Q_W       = FRAC_BITS + 1;
   localparam int F_W       = FRAC_BITS;
   localparam int H6_W      = FRAC_BITS + 3;
   localparam int SEC_W     = H6_W - F_W;
   localparam int CH_W      = 8;
   localparam int CMP_W     = (IN_W > Q_W) ? IN_W : Q_W;

   localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

   // hue sectors, each one sixth of a turn
   localparam logic [SEC_W-1:0] SEC_RED     = SEC_W'(0);
   localparam logic [SEC_W-1:0] SEC_YELLOW  = SEC_W'(1);
   localparam logic [SEC_W-1:0] SEC_GREEN   = SEC_W'(2);
   localparam logic [SEC_W-1:0] SEC_CYAN    = SEC_W'(3);
   localparam logic [SEC_W-1:0] SEC_BLUE    = SEC_W'(4);
   localparam logic [SEC_W-1:0] SEC_MAGENTA = SEC_W'(5);

   // front stage result: clamped operands, sector and fraction within it
   typedef struct packed {
      logic [Q_W-1:0]   val;
      logic [Q_W-1:0]   sat;
      logic [Q_W-1:0]   one_minus_sat;
      logic [SEC_W-1:0] sector;
      logic [F_W-1:0]   frac;
   } front_type;

   // product stage result: the three candidate channel values
   typedef struct packed {
      logic [Q_W-1:0]   val;
      logic [Q_W-1:0]   p;
      logic [Q_W-1:0]   q;
      logic [Q_W-1:0]   t;
      logic [SEC_W-1:0] sector;
   } pqt_type;

   // saturate an input fraction to one
   function automatic logic [Q_W-1:0] clamp_one(input logic [IN_W-1:0] x);
      logic [CMP_W-1:0] xe;
      xe = CMP_W'(x);
      if (xe > CMP_W'(ONE_Q)) begin
         return ONE_Q;
      end
      return Q_W'(xe);
   endfunction

   // (x * 255) >> FRAC_BITS as a shift and subtract
   function automatic logic [CH_W-1:0] to_byte(input logic [Q_W-1:0] x);
      logic [Q_W+CH_W-1:0] w;
      w = ((Q_W+CH_W)'(x) << CH_W) - (Q_W+CH_W)'(x);
      return w[FRAC_BITS +: CH_W];
   endfunction

endpackage

>>> rtl/hsvc_front.sv
`timescale 1ns / 1ps
// hsvc_front: first pipeline stage, clamps the inputs and splits hue into sector and fraction
// depends on hsvc_pkg

module hsvc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [hsvc_pkg::IN_W-1:0]     hue,
   input  logic [hsvc_pkg::IN_W-1:0]     saturation,
   input  logic [hsvc_pkg::IN_W-1:0]     brightness,
   output logic                          out_valid,
   output hsvc_pkg::front_type           out_data
);

   logic [hsvc_pkg::Q_W-1:0]  hue_clamped;
   logic [hsvc_pkg::F_W-1:0]  hue_wrapped;
   logic [hsvc_pkg::H6_W-1:0] hue6;
   hsvc_pkg::front_type       data_in;
   hsvc_pkg::front_type       data_ff;
   logic                      valid_in;
   logic                      valid_ff;

   // clamp, wrap a full turn to zero, scale hue by six
   always_comb begin
      hue_clamped = hsvc_pkg::clamp_one(hue);
      if (hue_clamped == hsvc_pkg::ONE_Q) begin
         hue_wrapped = '0;
      end else begin
         hue_wrapped = hue_clamped[hsvc_pkg::F_W-1:0];
      end
      hue6 = (hsvc_pkg::H6_W'(hue_wrapped) << 2) + (hsvc_pkg::H6_W'(hue_wrapped) << 1);
      data_in.val           = hsvc_pkg::clamp_one(brightness);
      data_in.sat           = hsvc_pkg::clamp_one(saturation);
      data_in.one_minus_sat = hsvc_pkg::ONE_Q - data_in.sat;
      data_in.sector        = hue6[hsvc_pkg::H6_W-1:hsvc_pkg::F_W];
      data_in.frac          = hue6[hsvc_pkg::F_W-1:0];
      valid_in              = in_valid;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/hsvc_prod.sv
`timescale 1ns / 1ps
// hsvc_prod: two multiplier stages that form p, q and t from value, saturation and fraction
// depends on hsvc_pkg

module hsvc_prod (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  hsvc_pkg::front_type in_data,
   output logic                out_valid,
   output hsvc_pkg::pqt_type   out_data
);

   localparam int P1_W = hsvc_pkg::Q_W + hsvc_pkg::F_W;
   localparam int P2_W = 2 * hsvc_pkg::Q_W;

   // stage a: s*f, s*(1-f) and p
   logic [hsvc_pkg::Q_W-1:0] one_minus_frac;
   logic [P1_W-1:0]          sf_prod;
   logic [P2_W-1:0]          sfc_prod;
   logic [P2_W-1:0]          p_prod;
   logic [hsvc_pkg::Q_W-1:0] qm_in;
   logic [hsvc_pkg::Q_W-1:0] tm_in;
   logic [hsvc_pkg::Q_W-1:0] qm_ff;
   logic [hsvc_pkg::Q_W-1:0] tm_ff;
   logic [hsvc_pkg::Q_W-1:0] pa_in;
   logic [hsvc_pkg::Q_W-1:0] pa_ff;
   logic [hsvc_pkg::Q_W-1:0] va_ff;
   logic [hsvc_pkg::SEC_W-1:0] seca_ff;
   logic                     valida_ff;

   // stage b: q and t
   logic [P2_W-1:0]          q_prod;
   logic [P2_W-1:0]          t_prod;
   hsvc_pkg::pqt_type        datab_in;
   hsvc_pkg::pqt_type        datab_ff;
   logic                     validb_ff;

   // first multiplier rank, complements taken after the products
   always_comb begin
      one_minus_frac = hsvc_pkg::ONE_Q - hsvc_pkg::Q_W'(in_data.frac);
      sf_prod  = P1_W'(in_data.sat) * P1_W'(in_data.frac);
      sfc_prod = P2_W'(in_data.sat) * P2_W'(one_minus_frac);
      p_prod   = P2_W'(in_data.val) * P2_W'(in_data.one_minus_sat);
      qm_in = hsvc_pkg::ONE_Q - sf_prod[hsvc_pkg::FRAC_BITS +: hsvc_pkg::Q_W];
      tm_in = hsvc_pkg::ONE_Q - sfc_prod[hsvc_pkg::FRAC_BITS +: hsvc_pkg::Q_W];
      pa_in = p_prod[hsvc_pkg::FRAC_BITS +: hsvc_pkg::Q_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valida_ff <= 1'b0;
      end else begin
         valida_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      qm_ff   <= qm_in;
      tm_ff   <= tm_in;
      pa_ff   <= pa_in;
      va_ff   <= in_data.val;
      seca_ff <= in_data.sector;
   end

   // second multiplier rank scales by value
   always_comb begin
      q_prod = P2_W'(va_ff) * P2_W'(qm_ff);
      t_prod = P2_W'(va_ff) * P2_W'(tm_ff);
      datab_in.val    = va_ff;
      datab_in.p      = pa_ff;
      datab_in.q      = q_prod[hsvc_pkg::FRAC_BITS +: hsvc_pkg::Q_W];
      datab_in.t      = t_prod[hsvc_pkg::FRAC_BITS +: hsvc_pkg::Q_W];
      datab_in.sector = seca_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         validb_ff <= 1'b0;
      end else begin
         validb_ff <= valida_ff;
      end
   end

   always_ff @(posedge clock) begin
      datab_ff <= datab_in;
   end

   assign out_valid = validb_ff;
   assign out_data  = datab_ff;

endmodule

>>> rtl/hsvc_back.sv
`timescale 1ns / 1ps
// hsvc_back: last stage, routes p, q, t and value to the channels by sector and scales to bytes
// depends on hsvc_pkg

module hsvc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  hsvc_pkg::pqt_type           in_data,
   output logic                        out_valid,
   output logic [hsvc_pkg::CH_W-1:0]   red,
   output logic [hsvc_pkg::CH_W-1:0]   green,
   output logic [hsvc_pkg::CH_W-1:0]   blue
);

   logic [hsvc_pkg::Q_W-1:0]  r_sel;
   logic [hsvc_pkg::Q_W-1:0]  g_sel;
   logic [hsvc_pkg::Q_W-1:0]  b_sel;
   logic [hsvc_pkg::CH_W-1:0] red_in;
   logic [hsvc_pkg::CH_W-1:0] green_in;
   logic [hsvc_pkg::CH_W-1:0] blue_in;
   logic [hsvc_pkg::CH_W-1:0] red_ff;
   logic [hsvc_pkg::CH_W-1:0] green_ff;
   logic [hsvc_pkg::CH_W-1:0] blue_ff;
   logic                      valid_ff;

   // six-sector channel assignment
   always_comb begin
      unique case (in_data.sector)
         hsvc_pkg::SEC_RED: begin
            r_sel = in_data.val; g_sel = in_data.t;   b_sel = in_data.p;
         end
         hsvc_pkg::SEC_YELLOW: begin
            r_sel = in_data.q;   g_sel = in_data.val; b_sel = in_data.p;
         end
         hsvc_pkg::SEC_GREEN: begin
            r_sel = in_data.p;   g_sel = in_data.val; b_sel = in_data.t;
         end
         hsvc_pkg::SEC_CYAN: begin
            r_sel = in_data.p;   g_sel = in_data.q;   b_sel = in_data.val;
         end
         hsvc_pkg::SEC_BLUE: begin
            r_sel = in_data.t;   g_sel = in_data.p;   b_sel = in_data.val;
         end
         default: begin
            r_sel = in_data.val; g_sel = in_data.p;   b_sel = in_data.q;
         end
      endcase
      red_in   = hsvc_pkg::to_byte(r_sel);
      green_in = hsvc_pkg::to_byte(g_sel);
      blue_in  = hsvc_pkg::to_byte(b_sel);
   end

   // output strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // output channels
   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign out_valid = valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

>>> rtl/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps
// hsv_to_rgb_converter_top: pipelined hsv to rgb converter, one pixel per clock
// depends on hsvc_pkg, hsvc_front, hsvc_prod, hsvc_back

// Usage
//   Request channel: drive req_hue, req_saturation and req_brightness (unsigned Q16
//   fractions, values above 1.0 saturate, a hue of 1.0 wraps to 0) and raise start.
//   A beat is taken at each clock edge with start high and busy low. busy is always
//   low, so a new beat may enter on every cycle.
//   Response channel: rsp_strobe is high for one cycle with rsp_red, rsp_green and
//   rsp_blue valid; the receiver must take the beat in that cycle.
//   Registered stages, in order: clamp and sector split, first multiplier rank,
//   second multiplier rank, channel select and byte scaling. Throughput: 1 beat
//   per cycle, set by the fully pipelined multiplier ranks.
//   Reset (synchronous, active high) clears the valid bits of all four stages;
//   beats in flight are dropped and no strobe follows them.
//   The receiver cannot stall, so the pipeline never holds.

module hsv_to_rgb_converter_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [hsvc_pkg::IN_W-1:0]   req_hue,
   input  logic [hsvc_pkg::IN_W-1:0]   req_saturation,
   input  logic [hsvc_pkg::IN_W-1:0]   req_brightness,
   output logic                        rsp_strobe,
   output logic [hsvc_pkg::CH_W-1:0]   rsp_red,
   output logic [hsvc_pkg::CH_W-1:0]   rsp_green,
   output logic [hsvc_pkg::CH_W-1:0]   rsp_blue
);

   logic                accept;
   logic                front_valid;
   hsvc_pkg::front_type front_data;
   logic                prod_valid;
   hsvc_pkg::pqt_type   prod_data;

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // clamp and sector split
   hsvc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .out_valid  (front_valid),
      .out_data   (front_data)
   );

   // p, q, t products
   hsvc_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (prod_valid),
      .out_data  (prod_data)
   );

   // channel routing and byte scaling
   hsvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_data   (prod_data),
      .out_valid (rsp_strobe),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

   // every response traces back to an earlier request beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("response strobe without a request beat");

   // every request beat produces a later response
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("request beat lost in the pipeline");

   // zero brightness gives black
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_brightness == '0) |->
         ##4 (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0))
      else $error("zero brightness did not give black");

   // zero saturation gives gray
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_saturation == '0) |->
         ##4 (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("zero saturation did not give gray");

endmodule
